### hw/rtl/ita_pkg.sv
// Package for the integer to ASCII formatter: transaction structs, FSM states,
// character codes and the digit table. No dependencies.
`timescale 1ns / 1ps

package ita_pkg;

  localparam int NUMBER_BITS_DEF = 32;
  localparam int MAX_FIELD_DEF   = 64;
  localparam int PREC_CAP        = 60;
  localparam int NUM_W           = 32;
  localparam int DIGIT_W         = 4;
  localparam int DIV_STEP        = 4;
  localparam int CNT_W           = 8;

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;
  localparam logic [4:0] BASE_OCT = 5'd8;
  localparam logic [4:0] BASE_HEX = 5'd16;

  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_OCT  = 2'd1;
  localparam logic [1:0] PFX_HEX  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [7:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [4:0]       base;
    logic [6:0]       width;
    logic [5:0]       precision;
    logic             left_justify;
    logic             zero_pad;
    logic             signed_conv;
    logic             plus_sign;
    logic             space_sign;
    logic             alt_form;
    logic             lower_hex;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       error;
  } out_item_t;

  // Per-transaction layout request, top level to field emitter
  typedef struct packed {
    logic [6:0] width;
    logic [5:0] precision;
    logic       zero_pad;
    logic       left_justify;
    logic       lower_hex;
    logic       has_sign;
    logic [7:0] sign_char;
    logic [1:0] pfx_len;
  } ita_fmt_t;

  // Divider status towards the top level
  typedef struct packed {
    logic               busy;
    logic               digit_valid;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } ita_div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LAYOUT,
    ST_EMIT,
    ST_ERR
  } ita_state_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic lc);
    digit_char = DIGIT_CHARS[d] | (lc ? CASE_BIT : 8'h00);
  endfunction

endpackage

### hw/rtl/ita_divider.sv
// Digit-serial divider: value shift register divided by the base four quotient
// bits per cycle, one digit (remainder) per pass. Depends on ita_pkg.
`timescale 1ns / 1ps

module ita_divider import ita_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [4:0]             base,
  input  logic [NUMBER_BITS-1:0] value,
  output ita_div_stat_t          stat
);

  localparam int VW     = ((NUMBER_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int PASSES = VW / DIV_STEP;
  localparam int CW     = $clog2(PASSES);

  logic [VW-1:0]      quo_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [4:0]         base_r;
  logic [CW-1:0]      cnt_r;
  logic               run_r;

  logic [DIGIT_W:0]    trial;
  logic [DIGIT_W-1:0]  rem_v;
  logic [DIV_STEP-1:0] qbits;
  logic [VW-1:0]       quo_shift;
  logic                pass_end;
  logic                quo_zero;

  always_comb begin
    rem_v = rem_r;
    qbits = '0;
    trial = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial = {rem_v, quo_r[VW-1-k]};
      if (trial >= base_r) begin
        qbits[DIV_STEP-1-k] = 1'b1;
        rem_v = DIGIT_W'(trial - base_r);
      end else begin
        rem_v = trial[DIGIT_W-1:0];
      end
    end
    quo_shift = {quo_r[VW-DIV_STEP-1:0], qbits};
  end

  assign pass_end = run_r && (cnt_r == CW'(PASSES - 1));
  assign quo_zero = (quo_shift == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (load) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      if (pass_end) begin
        cnt_r <= '0;
        if (quo_zero) begin
          run_r <= 1'b0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r  <= VW'(value);
      rem_r  <= '0;
      base_r <= base;
    end else if (run_r) begin
      quo_r <= quo_shift;
      rem_r <= pass_end ? '0 : rem_v;
    end
  end

  assign stat.busy        = run_r;
  assign stat.digit_valid = pass_end;
  assign stat.digit       = rem_v;
  assign stat.last        = quo_zero;

endmodule

### hw/rtl/ita_digit_stack.sv
// Digit stack: shift register that takes digits least significant first and
// hands them back most significant first. Depends on ita_pkg.
`timescale 1ns / 1ps

module ita_digit_stack import ita_pkg::*; #(
  parameter int DEPTH = NUMBER_BITS_DEF
) (
  input  logic               clk,
  input  logic               push,
  input  logic [DIGIT_W-1:0] push_digit,
  input  logic               pop,
  output logic [DIGIT_W-1:0] top_digit
);

  logic [DIGIT_W-1:0] stk_r [DEPTH];

  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[0] <= push_digit;
      for (int k = 1; k < DEPTH; k++) begin
        stk_r[k] <= stk_r[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        stk_r[k] <= stk_r[k+1];
      end
    end
  end

  assign top_digit = stk_r[0];

endmodule

### hw/rtl/ita_field_emit.sv
// Field emitter: works out segment boundaries of the field once, then picks
// one character per step from the running index. Depends on ita_pkg.
`timescale 1ns / 1ps

module ita_field_emit import ita_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int MAX_FIELD   = MAX_FIELD_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  ita_fmt_t                           fmt,
  input  logic [$clog2(NUMBER_BITS+1)-1:0]   nd,
  input  logic                               advance,
  input  logic [DIGIT_W-1:0]                 top_digit,
  output logic [7:0]                         character,
  output logic                               last,
  output logic                               pop
);

  localparam int IDX_W = $clog2(MAX_FIELD);

  logic [CNT_W-1:0] b_lead_r, b_sign_r, b_pfx_r, b_prec_r, b_dig_r;
  logic [IDX_W-1:0] last_idx_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       sign_r;
  logic             lc_r;

  logic [CNT_W-1:0] w_c, p_c, nd_c, precd, used, padn;
  logic [CNT_W-1:0] lead, zp, trail;
  logic [CNT_W-1:0] b_lead_nxt, b_sign_nxt, b_pfx_nxt, b_prec_nxt, b_dig_nxt, total;
  logic [IDX_W-1:0] last_idx_nxt;
  logic             zp_eff;
  logic [CNT_W-1:0] idx_c;
  logic             in_dig;

  always_comb begin
    w_c    = (CNT_W'(fmt.width) > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(fmt.width);
    p_c    = (CNT_W'(fmt.precision) > CNT_W'(PREC_CAP)) ? CNT_W'(PREC_CAP)
                                                          : CNT_W'(fmt.precision);
    nd_c   = CNT_W'(nd);
    precd  = (nd_c > p_c) ? nd_c : p_c;
    used   = CNT_W'(fmt.has_sign) + CNT_W'(fmt.pfx_len) + precd;
    padn   = (w_c > used) ? (w_c - used) : '0;
    zp_eff = fmt.zero_pad && !fmt.left_justify;
    lead   = (!zp_eff && !fmt.left_justify) ? padn : '0;
    zp     = zp_eff ? padn : '0;
    trail  = fmt.left_justify ? padn : '0;

    b_lead_nxt = lead;
    b_sign_nxt = lead + CNT_W'(fmt.has_sign);
    b_pfx_nxt  = b_sign_nxt + CNT_W'(fmt.pfx_len);
    b_prec_nxt = b_pfx_nxt + zp + (precd - nd_c);
    b_dig_nxt  = b_prec_nxt + nd_c;
    total      = b_dig_nxt + trail;
    last_idx_nxt = (total > CNT_W'(MAX_FIELD)) ? IDX_W'(MAX_FIELD - 1)
                                               : IDX_W'(total - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_lead_r   <= b_lead_nxt;
      b_sign_r   <= b_sign_nxt;
      b_pfx_r    <= b_pfx_nxt;
      b_prec_r   <= b_prec_nxt;
      b_dig_r    <= b_dig_nxt;
      last_idx_r <= last_idx_nxt;
      sign_r     <= fmt.sign_char;
      lc_r       <= fmt.lower_hex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (load) begin
      idx_r <= '0;
    end else if (advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_comb begin
    idx_c  = CNT_W'(idx_r);
    in_dig = 1'b0;
    priority if (idx_c < b_lead_r) begin
      character = CH_SPACE;
    end else if (idx_c < b_sign_r) begin
      character = sign_r;
    end else if (idx_c < b_pfx_r) begin
      character = (idx_c == b_sign_r) ? CH_ZERO : (CH_X | (lc_r ? CASE_BIT : 8'h00));
    end else if (idx_c < b_prec_r) begin
      character = CH_ZERO;
    end else if (idx_c < b_dig_r) begin
      character = digit_char(top_digit, lc_r);
      in_dig    = 1'b1;
    end else begin
      character = CH_SPACE;
    end
  end

  assign last = (idx_r == last_idx_r);
  assign pop  = advance && in_dig;

endmodule

### hw/rtl/integer_to_ascii_formatter.sv
// Flow: the divider produces one digit per pass over the value, then the field is laid
// out and the output register is loaded with the first character.
// Throughput: one character per cycle once emitting, unless out_ready stalls the output;
// the next transaction is taken only after the last character is in the output register.
// Reset: synchronous, active low; clears the FSM, divider control and output valid.
// Depends on ita_pkg, ita_divider, ita_digit_stack, ita_field_emit.
`timescale 1ns / 1ps

module integer_to_ascii_formatter import ita_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int MAX_FIELD   = MAX_FIELD_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int ND_W  = $clog2(NUMBER_BITS + 1);
  localparam int EXT_W = (NUMBER_BITS > NUM_W) ? NUMBER_BITS : NUM_W;

  ita_state_t    state_r, state_nxt;
  ita_fmt_t      fmt_r, fmt_nxt;
  ita_div_stat_t div_stat;
  out_item_t     out_data_r, out_item_nxt;
  logic          out_valid_r;
  logic [ND_W-1:0] nd_r;

  logic                   in_acc;
  logic [EXT_W-1:0]       num_ext;
  logic [NUMBER_BITS-1:0] num_v, abs_v;
  logic                   neg, base_ok;
  logic                   div_load, lay_load, advance, out_load;
  logic [DIGIT_W-1:0]     top_digit;
  logic [7:0]             emit_char;
  logic                   emit_last, pop;

  assign in_acc  = in_valid && in_ready;
  assign num_ext = EXT_W'(in_data.number);
  assign num_v   = num_ext[NUMBER_BITS-1:0];
  assign neg     = in_data.signed_conv && num_v[NUMBER_BITS-1];
  assign abs_v   = neg ? ((~num_v) + NUMBER_BITS'(1)) : num_v;
  assign base_ok = (in_data.base >= BASE_MIN) && (in_data.base <= BASE_MAX);

  always_comb begin
    fmt_nxt.width        = in_data.width;
    fmt_nxt.precision    = in_data.precision;
    fmt_nxt.zero_pad     = in_data.zero_pad;
    fmt_nxt.left_justify = in_data.left_justify;
    fmt_nxt.lower_hex    = in_data.lower_hex;
    fmt_nxt.has_sign     = 1'b0;
    fmt_nxt.sign_char    = CH_NUL;
    fmt_nxt.pfx_len      = PFX_NONE;
    if (in_data.signed_conv) begin
      priority if (neg) begin
        fmt_nxt.has_sign  = 1'b1;
        fmt_nxt.sign_char = CH_MINUS;
      end else if (in_data.plus_sign) begin
        fmt_nxt.has_sign  = 1'b1;
        fmt_nxt.sign_char = CH_PLUS;
      end else if (in_data.space_sign) begin
        fmt_nxt.has_sign  = 1'b1;
        fmt_nxt.sign_char = CH_SPACE;
      end
    end
    if (in_data.alt_form) begin
      priority if (in_data.base == BASE_HEX) begin
        fmt_nxt.pfx_len = PFX_HEX;
      end else if (in_data.base == BASE_OCT) begin
        fmt_nxt.pfx_len = PFX_OCT;
      end
    end
  end

  ita_divider #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (div_load),
    .base  (in_data.base),
    .value (abs_v),
    .stat  (div_stat)
  );

  ita_digit_stack #(
    .DEPTH(NUMBER_BITS)
  ) u_stack (
    .clk        (clk),
    .push       (div_stat.digit_valid),
    .push_digit (div_stat.digit),
    .pop        (pop),
    .top_digit  (top_digit)
  );

  ita_field_emit #(
    .NUMBER_BITS(NUMBER_BITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (lay_load),
    .fmt       (fmt_r),
    .nd        (nd_r),
    .advance   (advance),
    .top_digit (top_digit),
    .character (emit_char),
    .last      (emit_last),
    .pop       (pop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    div_load     = 1'b0;
    lay_load     = 1'b0;
    advance      = 1'b0;
    out_load     = 1'b0;
    out_item_nxt = '{character: emit_char, last: emit_last, error: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (base_ok) begin
            div_load  = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_ERR;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.digit_valid && div_stat.last) begin
          state_nxt = ST_LAYOUT;
        end
      end
      ST_LAYOUT: begin
        lay_load  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          advance  = 1'b1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (!out_valid_r || out_ready) begin
          out_load     = 1'b1;
          out_item_nxt = '{character: CH_NUL, last: 1'b1, error: 1'b1};
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fmt_r <= fmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r <= '0;
    end else if (in_acc) begin
      nd_r <= '0;
    end else if (div_stat.digit_valid) begin
      nd_r <= nd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy)
    else $error("divider busy while taking a new transaction");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r <= ND_W'(NUMBER_BITS))
    else $error("digit count beyond stack depth");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error) |-> out_data_r.last)
    else $error("error result not marked last");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && advance) |=> out_valid_r)
    else $error("emitted character not presented");

endmodule
